### rtl/swlp_pkg.sv
// shared constants and types for the sliding window latency percentile block
package swlp_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int TW    = 48;
    localparam int VW    = 32;
    localparam int WSW   = 17;
    localparam int MSW   = 11;
    localparam int MW    = 40;
    localparam int SCW   = 11;
    localparam int WMW   = WSW + 10;
    localparam int SW    = VW + CW;
    localparam int DVW   = SW + 8;
    localparam int YW    = CW + 8;
    localparam int RS    = YW + 7;
    localparam longint unsigned RK_L = ((64'd1 << RS) + 64'd99) / 64'd100;
    localparam logic [RS-1:0] RK = RS'(RK_L);

    localparam logic [6:0] P50 = 7'd50;
    localparam logic [6:0] P95 = 7'd95;
    localparam logic [6:0] P99 = 7'd99;
    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_MAX    = 1'b1;

    localparam logic [WSW-1:0] WINDOW_RESET = WSW'(60);
    localparam logic [MSW-1:0] MAX_RESET    = MSW'(1024);

    typedef struct packed {
        logic [TW-1:0] ts;
        logic [VW-1:0] val;
    } t_sample;

endpackage

### rtl/swlp_ram.sv
// generic single write, single registered read ram
module swlp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/swlp_div.sv
// restoring divider, one quotient bit per cycle while busy, for the windowed mean
module swlp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [swlp_pkg::DVW-1:0] i_dividend,
    input  logic [swlp_pkg::CW-1:0]  i_divisor,
    output logic                     o_busy,
    output logic [swlp_pkg::DVW-1:0] o_quotient
);
    import swlp_pkg::*;

    localparam int DCW = $clog2(DVW + 1);

    logic           r_busy;
    logic [DCW-1:0] r_step;
    logic [DVW-1:0] r_q;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_d;
    logic [CW:0]    trial;
    logic           qbit;

    always_comb begin
        trial = {r_rem, r_q[DVW-1]};
        qbit  = (trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= DCW'(DVW);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVW-2:0], qbit};
            r_rem <= qbit ? CW'(trial - {1'b0, r_d}) : trial[CW-1:0];
            r_step <= r_step - 1'b1;
            if (r_step == DCW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;
endmodule

### rtl/sliding_window_latency_percentiles.sv
// top level: sample ring in ram, record expiry, query scan with radix selection
// record: append, then an expiry check of the oldest sample until one is live, then the limit trim; no result
// query: a stats pass over the stored samples, the rank states S_RANK1 and S_RANK2, then 32 bit passes
//   over the stored samples, then a wait on the mean divider before the result strobe
// one item at a time; busy is high until the item is done, results cannot be stalled
// synchronous active-low reset empties the ring and restores window 60 s, limit 1024
module sliding_window_latency_percentiles (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_mode,
    input  logic [swlp_pkg::TW-1:0]  i_now_ms,
    input  logic [swlp_pkg::VW-1:0]  i_latency_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [swlp_pkg::WSW-1:0] i_cfg_data,
    output logic                     o_valid,
    output logic                     o_empty_set,
    output logic [swlp_pkg::SCW-1:0] o_sample_count,
    output logic [swlp_pkg::VW-1:0]  o_min_latency,
    output logic [swlp_pkg::VW-1:0]  o_max_latency,
    output logic [swlp_pkg::MW-1:0]  o_mean_latency,
    output logic [swlp_pkg::VW-1:0]  o_p50_latency,
    output logic [swlp_pkg::VW-1:0]  o_p95_latency,
    output logic [swlp_pkg::VW-1:0]  o_p99_latency
);
    import swlp_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_APPEND  = 4'd1;
    localparam logic [3:0] S_EXP_RD  = 4'd2;
    localparam logic [3:0] S_EXP_CHK = 4'd3;
    localparam logic [3:0] S_LIMIT   = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_RANK1   = 4'd6;
    localparam logic [3:0] S_RANK2   = 4'd7;
    localparam logic [3:0] S_WAIT    = 4'd8;

    logic [3:0]     r_state;
    logic [WSW-1:0] r_window;
    logic [MSW-1:0] r_max_cfg;
    logic [TW-1:0]  r_now;
    logic [VW-1:0]  r_lat;
    logic [WMW-1:0] r_win_ms;
    logic [AW-1:0]  r_oldest;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic           r_pend;
    logic           r_bitmode;
    logic [CW-1:0]  r_n;
    logic [SW-1:0]  r_sum;
    logic [VW-1:0]  r_min;
    logic [VW-1:0]  r_max;
    logic [VW-1:0]  r_bmask;
    logic [VW-1:0]  r_hmask;
    logic [VW-1:0]  r_pfx [3];
    logic [CW-1:0]  r_k   [3];
    logic [CW-1:0]  r_cnt [3];
    logic [YW-1:0]  r_y   [3];

    logic           r_valid;
    logic           r_empty;
    logic [SCW-1:0] r_ocount;
    logic [VW-1:0]  r_omin;
    logic [VW-1:0]  r_omax;
    logic [MW-1:0]  r_omean;
    logic [VW-1:0]  r_op50;
    logic [VW-1:0]  r_op95;
    logic [VW-1:0]  r_op99;

    logic           accept;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    t_sample        ram_wdata;
    t_sample        rd;
    logic           app_full;
    logic [AW-1:0]  app_old;
    logic [CW-1:0]  app_cnt;
    logic           inw;
    logic [CW-1:0]  lim;
    logic           issue;
    logic           pass_done;
    logic           div_start;
    logic           div_busy;
    logic [DVW-1:0] div_q;
    logic [6:0]     pct [3];

    assign pct[0] = P50;
    assign pct[1] = P95;
    assign pct[2] = P99;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        app_full  = (r_count == CW'(DEPTH));
        app_old   = r_oldest + AW'(app_full);
        app_cnt   = r_count - CW'(app_full);
        ram_we    = (r_state == S_APPEND);
        ram_waddr = app_old + app_cnt[AW-1:0];
        ram_wdata = '{ts: r_now, val: r_lat};
        ram_raddr = (r_state == S_SCAN) ? (r_oldest + r_idx[AW-1:0]) : r_oldest;
        inw       = ({1'b0, rd.ts} + (TW+1)'(r_win_ms)) >= {1'b0, r_now};
        if (32'(r_max_cfg) > 32'(DEPTH)) begin
            lim = CW'(DEPTH);
        end else begin
            lim = CW'(r_max_cfg);
        end
        issue     = (r_state == S_SCAN) && (r_idx < r_count);
        pass_done = (r_state == S_SCAN) && (r_idx == r_count) && !r_pend;
        div_start = (r_state == S_RANK1);
    end

    swlp_ram #(
        .W ($bits(t_sample)),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    swlp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, 8'd0}),
        .i_divisor  (r_n),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // configuration beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_max_cfg <= MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW: r_window  <= i_cfg_data;
                CFG_MAX:    r_max_cfg <= i_cfg_data[MSW-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_pend  <= issue;
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now     <= i_now_ms;
                        r_lat     <= i_latency_value;
                        r_win_ms  <= WMW'(r_window) * WMW'(MS_PER_SEC);
                        r_idx     <= '0;
                        r_n       <= '0;
                        r_sum     <= '0;
                        r_bitmode <= 1'b0;
                        r_state   <= i_mode ? S_SCAN : S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_oldest <= app_old;
                    r_count  <= app_cnt + 1'b1;
                    r_state  <= S_EXP_RD;
                end
                S_EXP_RD: begin
                    r_state <= S_EXP_CHK;
                end
                S_EXP_CHK: begin
                    if ((r_count != '0) && !inw) begin
                        r_oldest <= r_oldest + 1'b1;
                        r_count  <= r_count - 1'b1;
                        r_state  <= S_EXP_RD;
                    end else begin
                        r_state <= S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    if (r_count > lim) begin
                        r_oldest <= r_oldest + AW'(r_count - lim);
                        r_count  <= lim;
                    end
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_pend && inw) begin
                        if (!r_bitmode) begin
                            r_n   <= r_n + 1'b1;
                            r_sum <= r_sum + SW'(rd.val);
                            if ((r_n == '0) || (rd.val < r_min)) begin
                                r_min <= rd.val;
                            end
                            if ((r_n == '0) || (rd.val > r_max)) begin
                                r_max <= rd.val;
                            end
                        end else begin
                            for (int j = 0; j < 3; j++) begin
                                if ((((rd.val ^ r_pfx[j]) & r_hmask) == '0)
                                    && ((rd.val & r_bmask) == '0)) begin
                                    r_cnt[j] <= r_cnt[j] + 1'b1;
                                end
                            end
                        end
                    end
                    if (pass_done) begin
                        r_idx <= '0;
                        if (!r_bitmode) begin
                            if (r_n == '0) begin
                                r_valid  <= 1'b1;
                                r_empty  <= 1'b1;
                                r_ocount <= '0;
                                r_omin   <= '0;
                                r_omax   <= '0;
                                r_omean  <= '0;
                                r_op50   <= '0;
                                r_op95   <= '0;
                                r_op99   <= '0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_RANK1;
                            end
                        end else begin
                            // decide this bit of each selected value
                            for (int j = 0; j < 3; j++) begin
                                r_cnt[j] <= '0;
                                if (r_k[j] >= r_cnt[j]) begin
                                    r_pfx[j] <= r_pfx[j] | r_bmask;
                                    r_k[j]   <= r_k[j] - r_cnt[j];
                                end
                            end
                            r_hmask <= r_hmask | r_bmask;
                            r_bmask <= r_bmask >> 1;
                            if (r_bmask[0]) begin
                                r_state <= S_WAIT;
                            end
                        end
                    end
                end
                S_RANK1: begin
                    for (int j = 0; j < 3; j++) begin
                        r_y[j] <= YW'(pct[j]) * YW'(r_n) + YW'(99);
                    end
                    r_state <= S_RANK2;
                end
                S_RANK2: begin
                    // ceil(p*n/100)-1 via reciprocal multiply
                    for (int j = 0; j < 3; j++) begin
                        r_k[j]   <= CW'(((YW+RS)'(r_y[j]) * (YW+RS)'(RK)) >> RS) - 1'b1;
                        r_cnt[j] <= '0;
                        r_pfx[j] <= '0;
                    end
                    r_bmask   <= {1'b1, {(VW-1){1'b0}}};
                    r_hmask   <= '0;
                    r_bitmode <= 1'b1;
                    r_idx     <= '0;
                    r_state   <= S_SCAN;
                end
                S_WAIT: begin
                    if (!div_busy) begin
                        r_valid  <= 1'b1;
                        r_empty  <= 1'b0;
                        r_ocount <= SCW'(r_n);
                        r_omin   <= r_min;
                        r_omax   <= r_max;
                        r_omean  <= div_q[MW-1:0];
                        r_op50   <= r_pfx[0];
                        r_op95   <= r_pfx[1];
                        r_op99   <= r_pfx[2];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_empty_set    = r_empty;
    assign o_sample_count = r_ocount;
    assign o_min_latency  = r_omin;
    assign o_max_latency  = r_omax;
    assign o_mean_latency = r_omean;
    assign o_p50_latency  = r_op50;
    assign o_p95_latency  = r_op95;
    assign o_p99_latency  = r_op99;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("ring count above depth");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe while still busy");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past stored count");

    a_wait_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK2) |-> div_busy)
        else $error("divider not running for mean");
endmodule

### bench/tb.sv
// testbench for the sliding window latency percentile block
module tb;
    import swlp_pkg::*;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam int   CYCLE_LIMIT = 80000000;
    localparam int   EXP_DEPTH   = 16;

    typedef struct packed {
        logic          empty_set;
        logic [SCW-1:0] count;
        logic [VW-1:0] min_v;
        logic [VW-1:0] max_v;
        logic [MW-1:0] mean_v;
        logic [VW-1:0] p50;
        logic [VW-1:0] p95;
        logic [VW-1:0] p99;
    } t_stats;

    class window_scoreboard;
        bit [TW-1:0]    times[DEPTH];
        bit [VW-1:0]    vals[DEPTH];
        int unsigned    head;
        int unsigned    held;
        bit [WSW-1:0]   win_s;
        bit [MSW-1:0]   limit_reg;
        bit [VW-1:0]    srt[DEPTH];
        int unsigned    n_srt;
        t_stats         exp_q[EXP_DEPTH];
        int unsigned    exp_rd;
        int unsigned    exp_wr;

        function new();
            head = 0;
            held = 0;
            n_srt = 0;
            exp_rd = 0;
            exp_wr = 0;
            win_s = WINDOW_RESET;
            limit_reg = MAX_RESET;
        endfunction

        function void set_reg(logic idx, logic [WSW-1:0] d);
            if (idx == CFG_WINDOW) win_s = d;
            else limit_reg = d[MSW-1:0];
        endfunction

        function bit live(bit [TW-1:0] t, bit [TW-1:0] now);
            return (64'(t) + 64'(win_s) * 64'd1000) >= 64'(now);
        endfunction

        function void drop_oldest();
            if (held == 0) return;
            head = (head + 1) % DEPTH;
            held--;
        endfunction

        function bit [VW-1:0] pick(int unsigned n, int unsigned p);
            longint unsigned idx;
            idx = (longint'(p) * n + 99) / 100;
            idx = (idx == 0) ? 0 : idx - 1;
            if (idx >= n) idx = n - 1;
            return srt[idx];
        endfunction

        function void note(logic m, bit [TW-1:0] now, bit [VW-1:0] lat);
            longint unsigned total;
            int unsigned     lim;
            int unsigned     slot;
            int unsigned     j;
            bit [VW-1:0]     v;
            t_stats          e;
            if (m == MODE_RECORD) begin
                if (held >= DEPTH) drop_oldest();
                times[(head + held) % DEPTH] = now;
                vals[(head + held) % DEPTH] = lat;
                held++;
                while (held > 0 && !live(times[head], now)) drop_oldest();
                lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
                while (held > lim) drop_oldest();
                return;
            end
            // windowed values in ascending order
            n_srt = 0;
            for (int i = 0; i < held; i++) begin
                slot = (head + i) % DEPTH;
                if (live(times[slot], now)) begin
                    v = vals[slot];
                    j = n_srt;
                    while (j > 0 && srt[j - 1] > v) begin
                        srt[j] = srt[j - 1];
                        j--;
                    end
                    srt[j] = v;
                    n_srt++;
                end
            end
            e = '0;
            if (n_srt == 0) begin
                e.empty_set = 1'b1;
            end else begin
                total = 0;
                for (int i = 0; i < n_srt; i++) total += srt[i];
                e.count  = SCW'(n_srt);
                e.min_v  = srt[0];
                e.max_v  = srt[n_srt - 1];
                e.mean_v = MW'((total << 8) / n_srt);
                e.p50    = pick(n_srt, 50);
                e.p95    = pick(n_srt, 95);
                e.p99    = pick(n_srt, 99);
            end
            exp_q[exp_wr % EXP_DEPTH] = e;
            exp_wr++;
        endfunction

        function int pending();
            return int'(exp_wr - exp_rd);
        endfunction

        // empty string when the beat matches
        function string check(t_stats got);
            t_stats e;
            if (exp_wr == exp_rd) return "result beat with no query waiting";
            e = exp_q[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (got === e) return "";
            return $sformatf({"empty %0d/%0d cnt %0d/%0d min %0h/%0h max %0h/%0h ",
                "mean %0h/%0h p50 %0h/%0h p95 %0h/%0h p99 %0h/%0h (got/exp)"},
                got.empty_set, e.empty_set, got.count, e.count, got.min_v, e.min_v,
                got.max_v, e.max_v, got.mean_v, e.mean_v, got.p50, e.p50,
                got.p95, e.p95, got.p99, e.p99);
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    logic           i_mode = 1'b0;
    logic [TW-1:0]  i_now_ms = '0;
    logic [VW-1:0]  i_latency_value = '0;
    logic           i_cfg_valid = 1'b0;
    logic           i_cfg_index = 1'b0;
    logic [WSW-1:0] i_cfg_data = '0;
    logic           o_busy, o_cfg_ready, o_valid, o_empty_set;
    logic [SCW-1:0] o_sample_count;
    logic [VW-1:0]  o_min_latency, o_max_latency, o_p50_latency, o_p95_latency, o_p99_latency;
    logic [MW-1:0]  o_mean_latency;

    sliding_window_latency_percentiles uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    window_scoreboard sb = new();
    int errors = 0;
    int cycles = 0;
    bit [TW-1:0] clock_ms = '0;
    int burst_left = 0;
    bit [WSW-1:0] windows[8] = '{1, 2, 5, 30, 0, 86400, 131071, 3};
    bit [MSW-1:0] limits[8]  = '{1, 5, 17, 40, 0, 63, 24, 2};

    task automatic report(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        string msg;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note(i_mode, i_now_ms, i_latency_value);
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (o_valid) begin
                msg = sb.check({o_empty_set, o_sample_count, o_min_latency, o_max_latency,
                    o_mean_latency, o_p50_latency, o_p95_latency, o_p99_latency});
                if (msg != "") report(msg);
            end
        end
    end

    // start stays high across back-to-back beats; only gaps lower it
    task automatic send(logic m, bit [TW-1:0] now, bit [VW-1:0] lat);
        i_start <= 1'b1;
        i_mode <= m;
        i_now_ms <= now;
        i_latency_value <= lat;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap == 0) return;
        i_start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic settle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || o_busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [WSW-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bit [VW-1:0] rand_lat();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20);
            1: return $urandom_range(0, 5000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int count);
        bit [TW-1:0] step;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1: step = '0;
                2: step = TW'($urandom_range(0, 200000));
                default: step = TW'($urandom_range(0, 2500));
            endcase
            clock_ms += step;
            send(($urandom_range(0, 9) < 3) ? MODE_QUERY : MODE_RECORD, clock_ms, rand_lat());
            pace();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty window, value extremes, cutoff below zero, backward time
        send(MODE_QUERY, 48'd0, 32'd0);
        send(MODE_RECORD, 48'd0, 32'd0);
        send(MODE_RECORD, 48'd10, 32'hFFFF_FFFF);
        send(MODE_RECORD, 48'd20, 32'd7);
        send(MODE_QUERY, 48'd30, 32'hFFFF_FFFF);
        send(MODE_RECORD, 48'd60000, 32'd5);
        send(MODE_QUERY, 48'd60011, 32'd0);
        send(MODE_QUERY, 48'd5, 32'd0);
        send(MODE_RECORD, 48'd100, 32'd9);
        send(MODE_QUERY, 48'd200000, 32'd0);
        send(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 32'hAAAA_AAAA);
        send(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 32'h5555_5555);
        send(MODE_QUERY, 48'hFFFF_FFFF_FFFF, 32'd0);
        settle();
        write_reg(CFG_WINDOW, 17'd0);
        write_reg(CFG_MAX, 17'h1F803);
        send(MODE_RECORD, 48'd1000, 32'd4);
        send(MODE_RECORD, 48'd1000, 32'd2);
        send(MODE_RECORD, 48'd1000, 32'd8);
        send(MODE_QUERY, 48'd1000, 32'd0);
        send(MODE_QUERY, 48'd1001, 32'd0);
        settle();
        write_reg(CFG_MAX, 17'd0);
        send(MODE_RECORD, 48'd1002, 32'd1);
        send(MODE_QUERY, 48'd1002, 32'd0);
        settle();

        clock_ms = 48'd2000;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_WINDOW, windows[ph]);
            write_reg(CFG_MAX, {6'($urandom), limits[ph]});
            if (ph == 6) clock_ms = TW'({$urandom, $urandom} >> 16);
            random_items(44);
            settle();
        end

        // long window with the limit above capacity
        write_reg(CFG_WINDOW, 17'd86400);
        write_reg(CFG_MAX, 17'd2047);
        for (int k = 0; k < 150; k++) begin
            clock_ms += TW'($urandom_range(0, 3));
            send(MODE_RECORD, clock_ms, rand_lat());
            if (k == 75 || k == 148) send(MODE_QUERY, clock_ms, $urandom);
        end
        send(MODE_QUERY, clock_ms, 32'd0);
        settle();
        write_reg(CFG_MAX, 17'd1024);
        send(MODE_QUERY, clock_ms + 48'd86400000, 32'd0);
        send(MODE_QUERY, clock_ms + 48'd86400001, 32'd0);
        settle();
        write_reg(CFG_MAX, 17'd12);
        write_reg(CFG_WINDOW, 17'd1);
        random_items(60);

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
rtl/swlp_pkg.sv
rtl/swlp_ram.sv
rtl/swlp_div.sv
rtl/sliding_window_latency_percentiles.sv
bench/tb.sv
